/* design/psch_pkg.sv */
// Shared types and codes for the preemptive priority scheduler.
// No dependencies; imported by every module of the block.
package psch_pkg;

   localparam int TIME_W = 16;
   localparam int PRIO_W = 8;
   localparam int SLOT_W = 4;
   localparam int DEF_ENTRIES = 16;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef enum logic {
      CSR_WINDOW_BEST  = 1'b0,
      CSR_WINDOW_WORST = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              cmd;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [PRIO_W-1:0] prio;
   } req_type;

   typedef struct packed {
      logic              ran_valid;
      logic [SLOT_W-1:0] ran_slot;
      logic              finished;
      logic [TIME_W-1:0] finish_time;
      logic [TIME_W-1:0] turnaround;
      logic [TIME_W-1:0] waiting;
      logic              all_done;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic sample;
      logic elig;
   } pick_ctl_type;

   typedef struct packed {
      logic              found;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [TIME_W-1:0] remaining;
   } pick_type;

endpackage

/* design/psch_mem.sv */
// Entry table and remaining-work store, one write and one registered read port.
// Depends on psch_pkg.
module psch_mem #(
   parameter int ENTRIES = psch_pkg::DEF_ENTRIES
) (
   input  logic                                 clock,
   input  logic                                 we_entry,
   input  logic                                 we_rem,
   input  logic [$clog2(ENTRIES)-1:0]           waddr,
   input  psch_pkg::entry_type                  wentry,
   input  logic [psch_pkg::TIME_W-1:0]          wrem,
   input  logic [$clog2(ENTRIES)-1:0]           raddr,
   output psch_pkg::entry_type                  rentry,
   output logic [psch_pkg::TIME_W-1:0]          rrem
);
   import psch_pkg::*;

   entry_type         entry_mem [ENTRIES];
   logic [TIME_W-1:0] rem_mem   [ENTRIES];

   always_ff @(posedge clock) begin
      if (we_entry) begin
         entry_mem[waddr] <= wentry;
      end
      if (we_rem) begin
         rem_mem[waddr] <= wrem;
      end
      rentry <= entry_mem[raddr];
      rrem   <= rem_mem[raddr];
   end

endmodule

/* design/psch_pick.sv */
// Shared compare unit: tests one scanned entry per cycle and keeps the best one.
// Depends on psch_pkg.
module psch_pick #(
   parameter int ENTRIES = psch_pkg::DEF_ENTRIES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  psch_pkg::pick_ctl_type         ctl,
   input  logic [$clog2(ENTRIES)-1:0]     rd_idx,
   input  psch_pkg::entry_type            rd_entry,
   input  logic [psch_pkg::TIME_W-1:0]    rd_rem,
   input  logic [psch_pkg::TIME_W-1:0]    now_time,
   input  logic [psch_pkg::PRIO_W-1:0]    window_best,
   input  logic [psch_pkg::PRIO_W-1:0]    window_worst,
   output psch_pkg::pick_type             pick,
   output logic [$clog2(ENTRIES)-1:0]     pick_idx
);
   import psch_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   logic              found_ff,  found_in;
   logic [PRIO_W-1:0] prio_ff,   prio_in;
   logic [IDX_W-1:0]  idx_ff,    idx_in;
   logic [TIME_W-1:0] arr_ff,    arr_in;
   logic [TIME_W-1:0] bur_ff,    bur_in;
   logic [TIME_W-1:0] rem_ff,    rem_in;
   logic              take;

   always_comb begin
      take = ctl.sample && ctl.elig && (rd_entry.arrival <= now_time) &&
             (rd_entry.prio >= window_best) && (rd_entry.prio <= window_worst) &&
             (!found_ff || (rd_entry.prio < prio_ff));
      found_in = found_ff;
      prio_in  = prio_ff;
      idx_in   = idx_ff;
      arr_in   = arr_ff;
      bur_in   = bur_ff;
      rem_in   = rem_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         prio_in  = rd_entry.prio;
         idx_in   = rd_idx;
         arr_in   = rd_entry.arrival;
         bur_in   = rd_entry.burst;
         rem_in   = rd_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      prio_ff <= prio_in;
      idx_ff  <= idx_in;
      arr_ff  <= arr_in;
      bur_ff  <= bur_in;
      rem_ff  <= rem_in;
   end

   assign pick.found     = found_ff;
   assign pick.arrival   = arr_ff;
   assign pick.burst     = bur_ff;
   assign pick.remaining = rem_ff;
   assign pick_idx       = idx_ff;

endmodule

/* design/preemptive_priority_scheduler.sv */
// Preemptive priority scheduler top level: sequencer, counters and result register.
// Depends on psch_pkg, psch_mem and psch_pick.
//
// A load request (cmd 0) goes through the load and response states to the rsp_valid
// strobe; a tick request (cmd 1) runs a scan that reads the entry table one slot per
// cycle through a single read port into one shared compare unit, then a drain state,
// and three passes through one shared subtractor. busy stays high from the accepting
// edge until the cycle the result appears; a new request may start in the strobe
// cycle. The result is shown for one cycle only and cannot be stalled. Configuration
// writes are always ready and must only be issued while busy is low.
module preemptive_priority_scheduler #(
   parameter int ENTRIES = psch_pkg::DEF_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  psch_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   output psch_pkg::rsp_type             rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [psch_pkg::PRIO_W-1:0]   csr_wdata
);
   import psch_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_LOAD   = 8'b0000_0010,
      ST_SCAN   = 8'b0000_0100,
      ST_DRAIN  = 8'b0000_1000,
      ST_UPDATE = 8'b0001_0000,
      ST_TAT    = 8'b0010_0000,
      ST_WAIT   = 8'b0100_0000,
      ST_RESP   = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [ENTRIES-1:0] loaded_ff, loaded_in;
   logic [ENTRIES-1:0] zero_ff, zero_in;
   logic [CNT_W-1:0]  loaded_cnt_ff, loaded_cnt_in;
   logic [CNT_W-1:0]  done_cnt_ff, done_cnt_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [PRIO_W-1:0] win_best_ff, win_best_in;
   logic [PRIO_W-1:0] win_worst_ff, win_worst_in;
   logic              ran_ff, ran_in;
   logic [SLOT_W-1:0] ran_slot_ff, ran_slot_in;
   logic              fin_ff, fin_in;
   logic [TIME_W-1:0] fin_time_ff, fin_time_in;
   logic [TIME_W-1:0] tat_ff, tat_in;
   logic [TIME_W-1:0] wt_ff, wt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              we_entry, we_rem;
   logic [IDX_W-1:0]  waddr;
   entry_type         wentry;
   logic [TIME_W-1:0] wrem;
   entry_type         rd_entry;
   logic [TIME_W-1:0] rd_rem;
   pick_ctl_type      pick_ctl;
   pick_type          pick;
   logic [IDX_W-1:0]  pick_idx;

   logic [TIME_W-1:0] sub_a, sub_b, sub_diff;
   logic              accept;
   logic              slot_ok;
   logic [IDX_W-1:0]  load_idx;

   psch_mem #(.ENTRIES(ENTRIES)) u_mem (
      .clock    (clock),
      .we_entry (we_entry),
      .we_rem   (we_rem),
      .waddr    (waddr),
      .wentry   (wentry),
      .wrem     (wrem),
      .raddr    (scan_ff),
      .rentry   (rd_entry),
      .rrem     (rd_rem)
   );

   psch_pick #(.ENTRIES(ENTRIES)) u_pick (
      .clock        (clock),
      .reset        (reset),
      .ctl          (pick_ctl),
      .rd_idx       (rd_idx_ff),
      .rd_entry     (rd_entry),
      .rd_rem       (rd_rem),
      .now_time     (now_ff),
      .window_best  (win_best_ff),
      .window_worst (win_worst_ff),
      .pick         (pick),
      .pick_idx     (pick_idx)
   );

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign slot_ok   = (32'(req_ff.slot) < ENTRIES);
   assign load_idx  = IDX_W'(req_ff.slot);

   assign pick_ctl.clear  = accept;
   assign pick_ctl.sample = rd_vld_ff;
   assign pick_ctl.elig   = loaded_ff[rd_idx_ff] && !zero_ff[rd_idx_ff];

   // shared subtractor, floored at zero
   always_comb begin
      sub_a = pick.remaining;
      sub_b = TIME_W'(1);
      case (state_ff)
         ST_TAT: begin
            sub_a = fin_time_ff;
            sub_b = pick.arrival;
         end
         ST_WAIT: begin
            sub_a = tat_ff;
            sub_b = pick.burst;
         end
         default: begin
            sub_a = pick.remaining;
            sub_b = TIME_W'(1);
         end
      endcase
      sub_diff = (sub_a >= sub_b) ? (sub_a - sub_b) : '0;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      scan_in       = scan_ff;
      rd_idx_in     = rd_idx_ff;
      rd_vld_in     = 1'b0;
      loaded_in     = loaded_ff;
      zero_in       = zero_ff;
      loaded_cnt_in = loaded_cnt_ff;
      done_cnt_in   = done_cnt_ff;
      now_in        = now_ff;
      win_best_in   = win_best_ff;
      win_worst_in  = win_worst_ff;
      ran_in        = ran_ff;
      ran_slot_in   = ran_slot_ff;
      fin_in        = fin_ff;
      fin_time_in   = fin_time_ff;
      tat_in        = tat_ff;
      wt_in         = wt_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      we_entry      = 1'b0;
      we_rem        = 1'b0;
      waddr         = load_idx;
      wentry        = '{arrival: req_ff.arrival, burst: req_ff.burst, prio: req_ff.prio};
      wrem          = req_ff.burst;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW_BEST:  win_best_in  = csr_wdata;
            CSR_WINDOW_WORST: win_worst_in = csr_wdata;
            default:          win_best_in  = win_best_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in  = req_payload;
               scan_in = '0;
               ran_in  = 1'b0;
               fin_in  = 1'b0;
               state_in = (req_payload.cmd == CMD_TICK) ? ST_SCAN : ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (slot_ok) begin
               we_entry = 1'b1;
               we_rem   = 1'b1;
               loaded_in[load_idx] = 1'b1;
               zero_in[load_idx]   = (req_ff.burst == '0);
               if (!loaded_ff[load_idx]) begin
                  loaded_cnt_in = loaded_cnt_ff + CNT_W'(1);
               end
               case ({loaded_ff[load_idx] && zero_ff[load_idx], req_ff.burst == '0})
                  2'b10:   done_cnt_in = done_cnt_ff - CNT_W'(1);
                  2'b01:   done_cnt_in = done_cnt_ff + CNT_W'(1);
                  default: done_cnt_in = done_cnt_ff;
               endcase
            end
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            rd_vld_in = 1'b1;
            rd_idx_in = scan_ff;
            scan_in   = scan_ff + IDX_W'(1);
            if (scan_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            fin_time_in = (now_ff == TIME_MAX) ? TIME_MAX : now_ff + TIME_W'(1);
            if (pick.found) begin
               waddr       = pick_idx;
               wrem        = sub_diff;
               we_rem      = 1'b1;
               ran_in      = 1'b1;
               ran_slot_in = SLOT_W'(pick_idx);
               if (sub_diff == '0) begin
                  fin_in            = 1'b1;
                  zero_in[pick_idx] = 1'b1;
                  done_cnt_in       = done_cnt_ff + CNT_W'(1);
               end
            end
            state_in = ST_TAT;
         end
         ST_TAT: begin
            tat_in   = sub_diff;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            wt_in    = sub_diff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid_in       = 1'b1;
            rsp_in.ran_valid   = ran_ff;
            rsp_in.ran_slot    = ran_ff ? ran_slot_ff : '0;
            rsp_in.finished    = fin_ff;
            rsp_in.finish_time = fin_ff ? fin_time_ff : '0;
            rsp_in.turnaround  = fin_ff ? tat_ff : '0;
            rsp_in.waiting     = fin_ff ? wt_ff : '0;
            rsp_in.all_done    = (done_cnt_ff == loaded_cnt_ff);
            if (req_ff.cmd == CMD_TICK && now_ff != TIME_MAX) begin
               now_in = now_ff + TIME_W'(1);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_vld_ff     <= 1'b0;
         loaded_ff     <= '0;
         zero_ff       <= '0;
         loaded_cnt_ff <= '0;
         done_cnt_ff   <= '0;
         now_ff        <= '0;
         win_best_ff   <= '0;
         win_worst_ff  <= '1;
         ran_ff        <= 1'b0;
         fin_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         loaded_ff     <= loaded_in;
         zero_ff       <= zero_in;
         loaded_cnt_ff <= loaded_cnt_in;
         done_cnt_ff   <= done_cnt_in;
         now_ff        <= now_in;
         win_best_ff   <= win_best_in;
         win_worst_ff  <= win_worst_in;
         ran_ff        <= ran_in;
         fin_ff        <= fin_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff      <= req_in;
      scan_ff     <= scan_in;
      rd_idx_ff   <= rd_idx_in;
      ran_slot_ff <= ran_slot_in;
      fin_time_ff <= fin_time_in;
      tat_ff      <= tat_in;
      wt_ff       <= wt_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_done_le_loaded: assert property (@(posedge clock) disable iff (reset)
      done_cnt_ff <= loaded_cnt_ff)
      else $error("finished count exceeds loaded count");

   a_fin_ran: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.finished |-> rsp_payload.ran_valid)
      else $error("finished reported without a run");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted request did not raise busy");
`endif

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for preemptive_priority_scheduler: directed and random requests,
// window register changes between phases, a scoreboard with its own scheduler predictor.
// Depends on psch_pkg and the preemptive_priority_scheduler RTL.
module tb_top;
   import psch_pkg::*;

   localparam int ENTRIES      = DEF_ENTRIES;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 600;
   localparam int ROUNDS       = 10;

   class sched_scoreboard;
      rsp_type           expected_rsp[$];
      int unsigned       mismatch_count;
      logic [TIME_W-1:0] now_time;
      logic [TIME_W-1:0] remaining [ENTRIES];
      logic [TIME_W-1:0] arrival_tbl [ENTRIES];
      logic [TIME_W-1:0] burst_tbl [ENTRIES];
      logic [PRIO_W-1:0] prio_tbl [ENTRIES];
      bit                loaded [ENTRIES];
      int unsigned       loaded_total;
      int unsigned       done_total;
      logic [PRIO_W-1:0] best_prio;
      logic [PRIO_W-1:0] worst_prio;

      function new();
         foreach (remaining[i]) begin
            remaining[i]   = '0;
            arrival_tbl[i] = '0;
            burst_tbl[i]   = '0;
            prio_tbl[i]    = '0;
            loaded[i]      = 1'b0;
         end
         mismatch_count = 0;
         now_time       = '0;
         loaded_total   = 0;
         done_total     = 0;
         best_prio      = '0;
         worst_prio     = '1;
      endfunction

      function void set_window(logic [PRIO_W-1:0] best_v, logic [PRIO_W-1:0] worst_v);
         best_prio  = best_v;
         worst_prio = worst_v;
      endfunction

      function void note_request(req_type r);
         rsp_type           e;
         int                pick;
         logic [TIME_W-1:0] fin;
         e = '0;
         if (r.cmd == CMD_LOAD) begin
            if (loaded[r.slot]) begin
               if (remaining[r.slot] == 0 && done_total > 0) done_total--;
            end else begin
               loaded[r.slot] = 1'b1;
               loaded_total++;
            end
            arrival_tbl[r.slot] = r.arrival;
            burst_tbl[r.slot]   = r.burst;
            prio_tbl[r.slot]    = r.prio;
            remaining[r.slot]   = r.burst;
            if (r.burst == 0) done_total++;
         end else begin
            pick = -1;
            for (int i = 0; i < ENTRIES; i++) begin
               if (remaining[i] != 0 && arrival_tbl[i] <= now_time &&
                   prio_tbl[i] >= best_prio && prio_tbl[i] <= worst_prio &&
                   (pick < 0 || prio_tbl[i] < prio_tbl[pick]))
                  pick = i;
            end
            if (pick >= 0) begin
               e.ran_valid = 1'b1;
               e.ran_slot  = SLOT_W'(pick);
               remaining[pick] = remaining[pick] - 1'b1;
               if (remaining[pick] == 0) begin
                  fin = (now_time == TIME_MAX) ? TIME_MAX : now_time + 1'b1;
                  e.finished    = 1'b1;
                  e.finish_time = fin;
                  e.turnaround  = (fin >= arrival_tbl[pick]) ? fin - arrival_tbl[pick] : '0;
                  e.waiting     = (e.turnaround >= burst_tbl[pick]) ?
                                  e.turnaround - burst_tbl[pick] : '0;
                  done_total++;
               end
            end
            if (now_time != TIME_MAX) now_time = now_time + 1'b1;
         end
         e.all_done = (done_total == loaded_total);
         expected_rsp.push_back(e);
      endfunction

      function void compare_field(string field, logic [TIME_W-1:0] exp_v,
                                  logic [TIME_W-1:0] got_v);
         if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", field, exp_v, got_v);
            mismatch_count++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("result strobe with no request outstanding");
            mismatch_count++;
         end else begin
            e = expected_rsp.pop_front();
            compare_field("ran_valid", e.ran_valid, got.ran_valid);
            compare_field("ran_slot", e.ran_slot, got.ran_slot);
            compare_field("finished", e.finished, got.finished);
            compare_field("finish_time", e.finish_time, got.finish_time);
            compare_field("turnaround", e.turnaround, got.turnaround);
            compare_field("waiting", e.waiting, got.waiting);
            compare_field("all_done", e.all_done, got.all_done);
         end
      endfunction
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              start       = 1'b0;
   logic              busy;
   req_type           req_payload = '0;
   logic              rsp_valid;
   rsp_type           rsp_payload;
   logic              csr_valid   = 1'b0;
   logic              csr_ready;
   logic              csr_index   = 1'b0;
   logic [PRIO_W-1:0] csr_wdata   = '0;

   bit                gaps_on      = 1'b1;
   int unsigned       stall_cycles = 0;
   sched_scoreboard   sb;

   initial begin
      forever #1 clock = ~clock;
   end

   preemptive_priority_scheduler #(
      .ENTRIES(ENTRIES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_payload);
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[preemptive_priority_scheduler] ERROR");
            $finish;
         end
      end
   end

   function automatic req_type make_req(cmd_type c, int unsigned s, int unsigned a,
                                         int unsigned b, int unsigned p);
      req_type r;
      r.cmd     = c;
      r.slot    = SLOT_W'(s);
      r.arrival = TIME_W'(a);
      r.burst   = TIME_W'(b);
      r.prio    = PRIO_W'(p);
      return r;
   endfunction

   function automatic req_type tick_req();
      return make_req(CMD_TICK, $urandom_range(0, 15), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 255));
   endfunction

   function automatic req_type random_request();
      int unsigned a;
      int unsigned b;
      int unsigned p;
      if ($urandom_range(0, 99) < 62) return tick_req();
      if ($urandom_range(0, 9) == 0) begin
         a = $urandom_range(0, 65535);
      end else begin
         a = sb.now_time + $urandom_range(0, 12);
         if (a > 65535) a = 65535;
      end
      b = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 6);
      p = $urandom_range(0, 1) ? $urandom_range(0, 255) : 40 + $urandom_range(0, 3);
      return make_req(CMD_LOAD, $urandom_range(0, 15), a, b, p);
   endfunction

   task automatic send_request(input req_type r);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
   endtask

   task automatic run_ticks(input int n);
      repeat (n) send_request(tick_req());
   endtask

   task automatic wait_until_idle();
      start <= 1'b0;
      while (sb.expected_rsp.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic program_window(input logic [PRIO_W-1:0] best_v,
                                 input logic [PRIO_W-1:0] worst_v);
      wait_until_idle();
      csr_valid <= 1'b1;
      csr_index <= CSR_WINDOW_BEST;
      csr_wdata <= best_v;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_WINDOW_WORST;
      csr_wdata <= worst_v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_window(best_v, worst_v);
   endtask

   initial begin
      int unsigned lo;
      int unsigned hi;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // nothing loaded yet, then table extremes, tie on priority, reload of done and pending
      run_ticks(1);
      send_request(make_req(CMD_LOAD, 0, 0, 1, 255));
      send_request(make_req(CMD_LOAD, 15, 65535, 65535, 0));
      send_request(make_req(CMD_LOAD, 5, 1, 2, 10));
      send_request(make_req(CMD_LOAD, 3, 0, 3, 10));
      run_ticks(6);
      send_request(make_req(CMD_LOAD, 5, 0, 1, 10));
      send_request(make_req(CMD_LOAD, 15, 2, 1, 200));
      run_ticks(4);
      // inverted window, then single-value windows at both ends
      program_window(8'd200, 8'd50);
      send_request(make_req(CMD_LOAD, 7, 0, 2, 100));
      run_ticks(2);
      program_window(8'd255, 8'd255);
      send_request(make_req(CMD_LOAD, 8, 0, 1, 255));
      run_ticks(2);
      program_window(8'd0, 8'd0);
      send_request(make_req(CMD_LOAD, 9, 0, 2, 0));
      run_ticks(2);

      for (int round = 0; round < ROUNDS; round++) begin
         lo = $urandom_range(0, 255);
         hi = $urandom_range(0, 255);
         case (round == 0 ? 0 : $urandom_range(0, 4))
            0: program_window(8'd0, 8'd255);
            1: program_window(PRIO_W'(lo > hi ? lo : hi + 1), PRIO_W'(lo > hi ? hi : lo));
            2: program_window(PRIO_W'(lo < hi ? lo : hi), PRIO_W'(lo < hi ? hi : lo));
            3: program_window(PRIO_W'(lo), PRIO_W'(lo));
            default: program_window(8'd0, PRIO_W'(hi));
         endcase
         gaps_on = (round < ROUNDS - 2) && ($urandom_range(0, 3) != 0);
         repeat (RANDOM_ITEMS / ROUNDS) send_request(random_request());
      end

      // finish two fresh entries with no idle gaps
      gaps_on = 1'b0;
      program_window(8'd0, 8'd255);
      send_request(make_req(CMD_LOAD, 0, 0, 3, 0));
      send_request(make_req(CMD_LOAD, 1, 0, 2, 0));
      run_ticks(20);

      wait_until_idle();
      repeat (30) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.expected_rsp.size() == 0) begin
         $display("[preemptive_priority_scheduler] OK");
      end else begin
         $display("[preemptive_priority_scheduler] ERROR");
      end
      $finish;
   end

endmodule
